[src/lldp_tlv_extractor_top_defines.svh]
// Assertion macros shared by the LLDP TLV extractor modules.
`ifndef LLDP_TLV_EXTRACTOR_TOP_DEFINES_SVH
`define LLDP_TLV_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define LTE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed");

`define LTE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define LTE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define LTE_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[src/lte_pkg.sv]
// Shared types and constants of the LLDP TLV extractor.
package lte_pkg;

    localparam logic [15:0] ETHERTYPE_RESET = 16'h88CC;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int TDATA_W = 96;
    localparam int TUSER_W = 3;

    typedef enum logic [2:0] {
        KIND_NAME_CLEAR = 3'd0,
        KIND_NAME_BYTE  = 3'd1,
        KIND_PORT_CLEAR = 3'd2,
        KIND_PORT_BYTE  = 3'd3,
        KIND_IPV4       = 3'd4,
        KIND_VLAN       = 3'd5,
        KIND_DONE       = 3'd6
    } kind_t;

    typedef struct packed {
        logic        has_tlv;
        kind_t       tlv_kind;
        logic [31:0] tlv_data;
        logic        has_done;
        logic [31:0] count;
        logic        was_lldp;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[src/lte_front.sv]
// Front end: EtherType check, frame counting and the TLV walk for each byte.
`include "lldp_tlv_extractor_top_defines.svh"

module lte_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               s_axis_tlast,
    input  lte_pkg::queue_stat_t q_stat,
    output logic               push,
    output lte_pkg::entry_t    push_entry
);

    typedef enum logic [3:0] {
        PH_HDR0 = 4'b0001,
        PH_HDR1 = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } phase_t;

    localparam logic [3:0] POS_TYPE_HI = 4'd12;
    localparam logic [3:0] POS_TYPE_LO = 4'd13;
    localparam logic [3:0] POS_FIRST   = 4'd14;
    localparam logic [3:0] POS_PAST    = 4'd15;

    localparam logic [6:0] TLV_END       = 7'd0;
    localparam logic [6:0] TLV_PORT_ID   = 7'd2;
    localparam logic [6:0] TLV_SYS_NAME  = 7'd5;
    localparam logic [6:0] TLV_MGMT_ADDR = 7'd8;
    localparam logic [6:0] TLV_ORG       = 7'd127;

    localparam logic [8:0] OFF_MGMT_SUB  = 9'd1;
    localparam logic [8:0] OFF_GATHER_LO = 9'd2;
    localparam logic [8:0] OFF_ORG_SUB   = 9'd3;
    localparam logic [8:0] OFF_VLAN_HI   = 9'd4;
    localparam logic [8:0] OFF_FINAL     = 9'd5;
    localparam logic [7:0] SUBTYPE_ONE   = 8'd1;

    logic [15:0] ethertype_reg;
    logic [3:0]  hp_reg, hp_next;
    logic        tm_reg, tm_next;
    phase_t      phase_reg, phase_next;
    logic [6:0]  type_reg, type_next;
    logic [8:0]  len_reg, len_next;
    logic [8:0]  off_reg, off_next;
    logic [31:0] gather_reg, gather_next;
    logic        sub_reg, sub_next;
    logic [31:0] cnt_reg, cnt_next;

    logic        accept;
    logic        has_tlv;
    lte_pkg::kind_t tlv_kind;
    logic [31:0] tlv_data;
    logic [7:0]  b;

    assign s_axis_tready = !q_stat.full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;

    always_comb begin
        hp_next     = hp_reg;
        tm_next     = tm_reg;
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        gather_next = gather_reg;
        sub_next    = sub_reg;
        cnt_next    = cnt_reg;
        has_tlv     = 1'b0;
        tlv_kind    = lte_pkg::KIND_NAME_CLEAR;
        tlv_data    = 32'd0;

        if (hp_reg < POS_FIRST) begin
            if (hp_reg == POS_TYPE_HI) begin
                tm_next = (b == ethertype_reg[15:8]);
            end else if (hp_reg == POS_TYPE_LO) begin
                tm_next = tm_reg && (b == ethertype_reg[7:0]);
            end
            hp_next = hp_reg + 4'd1;
        end else begin
            if (hp_reg == POS_FIRST) begin
                if (tm_reg) begin
                    cnt_next = cnt_reg + 32'd1;
                end
                hp_next = POS_PAST;
            end
            if (tm_reg && phase_reg != PH_STOP) begin
                case (phase_reg)
                    PH_HDR0: begin
                        type_next  = b[7:1];
                        len_next   = {b[0], 8'd0};
                        phase_next = PH_HDR1;
                    end
                    PH_HDR1: begin
                        len_next = {len_reg[8], b};
                        if (type_reg == TLV_END) begin
                            phase_next = PH_STOP;
                        end else begin
                            off_next    = 9'd0;
                            gather_next = 32'd0;
                            sub_next    = 1'b0;
                            if (type_reg == TLV_SYS_NAME) begin
                                has_tlv  = 1'b1;
                                tlv_kind = lte_pkg::KIND_NAME_CLEAR;
                            end else if (type_reg == TLV_PORT_ID) begin
                                has_tlv  = 1'b1;
                                tlv_kind = lte_pkg::KIND_PORT_CLEAR;
                            end
                            phase_next = (len_next == 9'd0) ? PH_HDR0 : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (type_reg == TLV_SYS_NAME) begin
                            has_tlv  = 1'b1;
                            tlv_kind = lte_pkg::KIND_NAME_BYTE;
                            tlv_data = {24'd0, b};
                        end else if (type_reg == TLV_PORT_ID) begin
                            if (off_reg != 9'd0) begin
                                has_tlv  = 1'b1;
                                tlv_kind = lte_pkg::KIND_PORT_BYTE;
                                tlv_data = {24'd0, b};
                            end
                        end else if (type_reg == TLV_MGMT_ADDR) begin
                            if (off_reg == OFF_MGMT_SUB) begin
                                sub_next = (b == SUBTYPE_ONE);
                            end
                            if (off_reg inside {[OFF_GATHER_LO:OFF_FINAL]}) begin
                                gather_next = {gather_reg[23:0], b};
                            end
                            if (off_reg == OFF_FINAL && sub_reg) begin
                                has_tlv  = 1'b1;
                                tlv_kind = lte_pkg::KIND_IPV4;
                                tlv_data = gather_next;
                            end
                        end else if (type_reg == TLV_ORG) begin
                            if (off_reg == OFF_ORG_SUB) begin
                                sub_next = (b == SUBTYPE_ONE);
                            end
                            if (off_reg == OFF_VLAN_HI || off_reg == OFF_FINAL) begin
                                gather_next = {gather_reg[23:0], b};
                            end
                            if (off_reg == OFF_FINAL && sub_reg) begin
                                has_tlv  = 1'b1;
                                tlv_kind = lte_pkg::KIND_VLAN;
                                tlv_data = {16'd0, gather_next[15:0]};
                            end
                        end
                        off_next = off_reg + 9'd1;
                        if (off_next >= len_reg) begin
                            phase_next = PH_HDR0;
                        end
                    end
                    default: begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
        end

        push_entry.has_tlv  = has_tlv;
        push_entry.tlv_kind = tlv_kind;
        push_entry.tlv_data = tlv_data;
        push_entry.has_done = s_axis_tlast;
        push_entry.count    = cnt_next;
        push_entry.was_lldp = tm_next && (hp_next == POS_PAST);

        if (s_axis_tlast) begin
            hp_next     = 4'd0;
            tm_next     = 1'b0;
            phase_next  = PH_HDR0;
            type_next   = 7'd0;
            len_next    = 9'd0;
            off_next    = 9'd0;
            gather_next = 32'd0;
            sub_next    = 1'b0;
        end
    end

    assign push = accept && (has_tlv || s_axis_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ethertype_reg <= lte_pkg::ETHERTYPE_RESET;
            hp_reg        <= 4'd0;
            tm_reg        <= 1'b0;
            phase_reg     <= PH_HDR0;
            type_reg      <= 7'd0;
            len_reg       <= 9'd0;
            off_reg       <= 9'd0;
            gather_reg    <= 32'd0;
            sub_reg       <= 1'b0;
            cnt_reg       <= 32'd0;
        end else begin
            if (cfg_wr_en) begin
                ethertype_reg <= cfg_wr_data;
            end
            if (accept) begin
                hp_reg     <= hp_next;
                tm_reg     <= tm_next;
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                len_reg    <= len_next;
                off_reg    <= off_next;
                gather_reg <= gather_next;
                sub_reg    <= sub_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    `LTE_ASSERT_NEXT(a_frame_end_clears, aclk, aresetn, accept && s_axis_tlast, hp_reg == 4'd0)
    `LTE_ASSERT_IMPLIES(a_push_on_accept, aclk, aresetn, push, accept)

endmodule

[src/lte_queue.sv]
// Short result queue between the front end and the output stage.
`include "lldp_tlv_extractor_top_defines.svh"

module lte_queue #(
    parameter int DEPTH = lte_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lte_pkg::entry_t      push_entry,
    input  logic                 pop,
    output lte_pkg::entry_t      head,
    output lte_pkg::queue_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lte_pkg::entry_t slot_reg [DEPTH];
    lte_pkg::entry_t slot_next [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_idx;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head = slot_reg[0];

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        wr_idx     = PW'(count_reg);
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            wr_idx = PW'(count_reg - CW'(1));
        end
        if (push) begin
            slot_next[wr_idx] = push_entry;
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `LTE_ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT)
    `LTE_ASSERT_IMPLIES(a_pop_not_empty, aclk, aresetn, pop, !stat.empty)

endmodule

[src/lte_back.sv]
// Output stage: splits queue entries into result items on the master stream.
`include "lldp_tlv_extractor_top_defines.svh"

module lte_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lte_pkg::entry_t              head,
    input  lte_pkg::queue_stat_t         q_stat,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [lte_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [lte_pkg::TUSER_W-1:0]  m_axis_tuser,
    output logic                         m_axis_tlast
);

    logic        valid_reg, valid_next;
    logic        second_reg, second_next;
    logic [lte_pkg::TDATA_W-1:0] data_reg, data_next;
    lte_pkg::kind_t kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        load;
    logic        emit_tlv;
    logic [7:0]  ch;
    logic [31:0] ip;
    logic [15:0] vl;

    assign load = !q_stat.empty && (!valid_reg || m_axis_tready);
    assign emit_tlv = head.has_tlv && !second_reg;

    always_comb begin
        ch = 8'd0;
        ip = 32'd0;
        vl = 16'd0;
        if (head.tlv_kind inside {lte_pkg::KIND_NAME_BYTE, lte_pkg::KIND_PORT_BYTE}) begin
            ch = head.tlv_data[7:0];
        end
        if (head.tlv_kind == lte_pkg::KIND_IPV4) begin
            ip = head.tlv_data;
        end
        if (head.tlv_kind == lte_pkg::KIND_VLAN) begin
            vl = head.tlv_data[15:0];
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        second_next = second_reg;
        data_next   = data_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (emit_tlv) begin
                kind_next = head.tlv_kind;
                data_next = {7'd0, 1'b0, 32'd0, vl, ip, ch};
                last_next = !head.has_done;
                if (head.has_done) begin
                    second_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                kind_next   = lte_pkg::KIND_DONE;
                data_next   = {7'd0, head.was_lldp, head.count, 16'd0, 32'd0, 8'd0};
                last_next   = 1'b1;
                second_next = 1'b0;
                pop         = 1'b1;
            end
        end else if (valid_reg && m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

    `LTE_ASSERT_IMPLIES(a_done_is_last, aclk, aresetn, valid_reg && kind_reg == lte_pkg::KIND_DONE, last_reg)

endmodule

[src/lldp_tlv_extractor_top.sv]
// LLDP TLV extractor top level: byte stream in, result items out.
//
// Frame bytes are taken one per clock whenever the result queue has room.
// The front end checks the EtherType, counts LLDP frames and walks the
// TLVs; each byte that causes results puts one entry in a QUEUE_DEPTH-entry
// queue, and the output stage turns an entry into one or two result items
// at one item per clock while they are taken. A byte gives two items only
// when it both finishes a TLV result and ends the frame, so the input runs
// at one byte per clock as long as the output side takes items; the queue
// absorbs short stalls. Entries pass the queue and the output register.
// The EtherType register is written through cfg_wr_en and cfg_wr_data.

module lldp_tlv_extractor_top #(
    parameter int QUEUE_DEPTH = lte_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [15:0]                  cfg_wr_data,   // match_ethertype
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // frame_byte
    input  logic                         s_axis_tlast,  // frame_last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // char_byte[7:0], ipv4_addr[39:8], vlan_id[55:40], frame_count[87:56],
    // was_lldp[88], zero fill[95:89]
    output logic [lte_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [lte_pkg::TUSER_W-1:0]  m_axis_tuser,  // kind
    output logic                         m_axis_tlast   // last_of_run
);

    lte_pkg::queue_stat_t q_stat;
    lte_pkg::entry_t      push_entry;
    lte_pkg::entry_t      head;
    logic                 push;
    logic                 pop;

    lte_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry)
    );

    lte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    lte_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the LLDP TLV extractor with a byte-level predictor and scoreboard.
`timescale 1ns / 1ps

localparam logic [6:0] TLV_END           = 7'd0;
localparam logic [6:0] TLV_PORT_ID       = 7'd2;
localparam logic [6:0] TLV_SYSTEM_NAME   = 7'd5;
localparam logic [6:0] TLV_MGMT_ADDR     = 7'd8;
localparam logic [6:0] TLV_ORG_SPECIFIC  = 7'd127;
localparam logic [7:0] SUBTYPE_IPV4      = 8'd1;
localparam logic [7:0] SUBTYPE_PORT_VLAN = 8'd1;

typedef enum logic [1:0] {WALK_HDR0, WALK_HDR1, WALK_BODY, WALK_STOP} walk_phase_t;

typedef struct {
    lte_pkg::kind_t              kind;
    logic [lte_pkg::TDATA_W-1:0] data;
    logic                        last;
} lldp_result_t;

class lldp_scoreboard;
    logic [15:0]  ethertype;
    logic [3:0]   hdr_pos;
    logic         type_ok;
    walk_phase_t  phase;
    logic [6:0]   tlv_typ;
    logic [8:0]   tlv_len;
    logic [8:0]   offset;
    logic [31:0]  gather;
    logic         sub_ok;
    logic [31:0]  frames;
    lldp_result_t run[$];
    lldp_result_t expected_results[$];
    int           errors;

    function new();
        ethertype = lte_pkg::ETHERTYPE_RESET;
        frames = '0;
        errors = 0;
        clear_walk();
    endfunction

    function void clear_walk();
        hdr_pos = '0;
        type_ok = 1'b0;
        phase = WALK_HDR0;
        tlv_typ = '0;
        tlv_len = '0;
        offset = '0;
        gather = '0;
        sub_ok = 1'b0;
    endfunction

    function void set_ethertype(logic [15:0] value);
        ethertype = value;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void add_result(lte_pkg::kind_t kind, logic [7:0] ch, logic [31:0] ip,
                             logic [15:0] vl, logic [31:0] cnt, logic lldp);
        lldp_result_t item;
        item.kind = kind;
        item.data = {7'd0, lldp, cnt, vl, ip, ch};
        item.last = 1'b0;
        run.push_back(item);
    endfunction

    function void walk_tlv(logic [7:0] b);
        case (phase)
            WALK_HDR0: begin
                tlv_typ = b[7:1];
                tlv_len = {b[0], 8'h00};
                phase = WALK_HDR1;
            end
            WALK_HDR1: begin
                tlv_len = tlv_len | {1'b0, b};
                if (tlv_typ == TLV_END) begin
                    phase = WALK_STOP;
                end else begin
                    offset = '0;
                    gather = '0;
                    sub_ok = 1'b0;
                    if (tlv_typ == TLV_SYSTEM_NAME) begin
                        add_result(lte_pkg::KIND_NAME_CLEAR, 8'h00, 32'h0, 16'h0, 32'h0, 1'b0);
                    end else if (tlv_typ == TLV_PORT_ID) begin
                        add_result(lte_pkg::KIND_PORT_CLEAR, 8'h00, 32'h0, 16'h0, 32'h0, 1'b0);
                    end
                    phase = (tlv_len == 9'd0) ? WALK_HDR0 : WALK_BODY;
                end
            end
            WALK_BODY: begin
                case (tlv_typ)
                    TLV_SYSTEM_NAME: begin
                        add_result(lte_pkg::KIND_NAME_BYTE, b, 32'h0, 16'h0, 32'h0, 1'b0);
                    end
                    TLV_PORT_ID: begin
                        if (offset >= 9'd1) begin
                            add_result(lte_pkg::KIND_PORT_BYTE, b, 32'h0, 16'h0, 32'h0, 1'b0);
                        end
                    end
                    TLV_MGMT_ADDR: begin
                        if (offset == 9'd1) sub_ok = (b == SUBTYPE_IPV4);
                        if (offset >= 9'd2 && offset <= 9'd5) gather = {gather[23:0], b};
                        if (offset == 9'd5 && sub_ok) begin
                            add_result(lte_pkg::KIND_IPV4, 8'h00, gather, 16'h0, 32'h0, 1'b0);
                        end
                    end
                    TLV_ORG_SPECIFIC: begin
                        if (offset == 9'd3) sub_ok = (b == SUBTYPE_PORT_VLAN);
                        if (offset == 9'd4 || offset == 9'd5) gather = {gather[23:0], b};
                        if (offset == 9'd5 && sub_ok) begin
                            add_result(lte_pkg::KIND_VLAN, 8'h00, 32'h0, gather[15:0], 32'h0,
                                       1'b0);
                        end
                    end
                    default: ;
                endcase
                offset = offset + 9'd1;
                if (offset >= tlv_len) phase = WALK_HDR0;
            end
            default: ;
        endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
        run.delete();
        if (hdr_pos < 4'd14) begin
            if (hdr_pos == 4'd12) begin
                type_ok = (b == ethertype[15:8]);
            end else if (hdr_pos == 4'd13) begin
                type_ok = type_ok && (b == ethertype[7:0]);
            end
            hdr_pos = hdr_pos + 4'd1;
        end else begin
            if (hdr_pos == 4'd14) begin
                if (type_ok) frames = frames + 32'd1;
                hdr_pos = 4'd15;
            end
            if (type_ok && phase != WALK_STOP) walk_tlv(b);
        end
        if (last) begin
            add_result(lte_pkg::KIND_DONE, 8'h00, 32'h0, 16'h0, frames,
                       type_ok && hdr_pos == 4'd15);
            clear_walk();
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_results.push_back(run[i]);
    endfunction

    function void field_cmp(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [2:0] kind, logic [lte_pkg::TDATA_W-1:0] data,
                               logic last);
        lldp_result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, actual kind %0d data %h",
                     $time, kind, data);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        field_cmp("kind", 32'(want.kind), 32'(kind));
        field_cmp("char_byte", 32'(want.data[7:0]), 32'(data[7:0]));
        field_cmp("ipv4_addr", want.data[39:8], data[39:8]);
        field_cmp("vlan_id", 32'(want.data[55:40]), 32'(data[55:40]));
        field_cmp("frame_count", want.data[87:56], data[87:56]);
        field_cmp("was_lldp", 32'(want.data[88]), 32'(data[88]));
        field_cmp("zero fill", 32'(want.data[lte_pkg::TDATA_W-1:89]),
                  32'(data[lte_pkg::TDATA_W-1:89]));
        field_cmp("last_of_run", 32'(want.last), 32'(last));
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [15:0]                 cfg_wr_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;
    logic                        s_axis_tlast = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [lte_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [lte_pkg::TUSER_W-1:0] m_axis_tuser;
    logic                        m_axis_tlast;

    lldp_scoreboard sb;
    logic [7:0]     frame_q[$];
    logic [15:0]    ethertype_now = lte_pkg::ETHERTYPE_RESET;
    int             bytes_sent = 0;
    int             burst_left = 0;
    bit             tx_idle = 1'b0;
    rx_mode_t       rx_mode = RX_ALWAYS;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    int             rx_tick = 0;
    int             cycles = 0;

    lldp_tlv_extractor_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 70);
                default: begin
                    rx_tick++;
                    m_axis_tready <= ((rx_tick % 7) < 4);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic pace();
        int gap;
        if (!tx_idle) return;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            pace();
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
        frame_q.delete();
    endtask

    task automatic push_header(input bit match);
        logic [15:0] et;
        repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
        et = match ? ethertype_now : 16'($urandom_range(0, 65535));
        if (!match && et == ethertype_now) et = et ^ 16'h0100;
        frame_q.push_back(et[15:8]);
        frame_q.push_back(et[7:0]);
    endtask

    task automatic push_tlv(input logic [6:0] typ, input logic [8:0] len);
        logic [7:0] b;
        frame_q.push_back({typ, len[8]});
        frame_q.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (typ == TLV_MGMT_ADDR && i == 1 && $urandom_range(0, 3) != 0) b = SUBTYPE_IPV4;
            if (typ == TLV_ORG_SPECIFIC && i == 3 && $urandom_range(0, 3) != 0) begin
                b = SUBTYPE_PORT_VLAN;
            end
            frame_q.push_back(b);
        end
    endtask

    task automatic push_random_tlv();
        int r;
        int rl;
        logic [6:0] typ;
        logic [8:0] len;
        r = $urandom_range(0, 99);
        if (r < 25) typ = TLV_SYSTEM_NAME;
        else if (r < 45) typ = TLV_PORT_ID;
        else if (r < 65) typ = TLV_MGMT_ADDR;
        else if (r < 85) typ = TLV_ORG_SPECIFIC;
        else if (r < 95) typ = 7'($urandom_range(1, 126));
        else typ = TLV_END;
        rl = $urandom_range(0, 99);
        if (rl < 5) begin
            len = 9'($urandom_range(256, 511));
        end else if ((typ == TLV_MGMT_ADDR || typ == TLV_ORG_SPECIFIC) && rl < 70) begin
            len = 9'($urandom_range(6, 8));
        end else begin
            len = 9'($urandom_range(0, 9));
        end
        push_tlv(typ, len);
    endtask

    task automatic random_frame();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            push_header(1'b1);
            n = $urandom_range(1, 4);
            repeat (n) push_random_tlv();
            if ($urandom_range(0, 1) == 1) begin
                push_tlv(TLV_END, 9'($urandom_range(0, 3)));
                repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
        end else if (r < 85) begin
            push_header(1'b0);
            repeat ($urandom_range(0, 2)) push_random_tlv();
        end else if (r < 95) begin
            n = $urandom_range(1, 16);
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
            if (n >= 14 && $urandom_range(0, 1) == 1) begin
                frame_q[12] = ethertype_now[15:8];
                frame_q[13] = ethertype_now[7:0];
            end
        end else begin
            repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        if (r < 85 && $urandom_range(0, 99) < 20) begin
            n = $urandom_range(1, frame_q.size());
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end
        if (frame_q.size() > 64) begin
            n = $urandom_range(15, 64);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end
        send_frame();
    endtask

    task automatic random_until(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) random_frame();
    endtask

    task automatic drain_pause();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_ethertype(input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_ethertype(value);
        ethertype_now = value;
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // One-byte frame, bare 14-byte header, and the shortest counted frame.
        frame_q = {8'hFF};
        send_frame();
        push_header(1'b1);
        send_frame();
        push_header(1'b1);
        frame_q.push_back(8'h00);
        send_frame();

        // Every TLV kind, an unknown type, an empty name, then type zero with a trailing byte.
        push_header(1'b1);
        frame_q = {frame_q, {TLV_SYSTEM_NAME, 1'b0}, 8'd1, 8'hFF};
        frame_q = {frame_q, {TLV_PORT_ID, 1'b0}, 8'd2, 8'h05, 8'h00};
        frame_q = {frame_q, {TLV_MGMT_ADDR, 1'b0}, 8'd6, 8'd5, SUBTYPE_IPV4,
                   8'hFF, 8'h00, 8'hFF, 8'h01};
        frame_q = {frame_q, {TLV_ORG_SPECIFIC, 1'b0}, 8'd6, 8'h00, 8'h80, 8'hC2,
                   SUBTYPE_PORT_VLAN, 8'hFF, 8'hFF};
        frame_q = {frame_q, {7'd100, 1'b0}, 8'd2, 8'hAA, 8'hBB};
        frame_q = {frame_q, {TLV_SYSTEM_NAME, 1'b0}, 8'd0};
        frame_q = {frame_q, {TLV_END, 1'b0}, 8'd0, 8'h0A};
        send_frame();

        // A frame with the wrong EtherType gives only its done item.
        push_header(1'b0);
        frame_q = {frame_q, {TLV_SYSTEM_NAME, 1'b0}, 8'd1, 8'h41};
        send_frame();

        // A short address TLV, then a VLAN whose last byte also ends the frame.
        push_header(1'b1);
        frame_q = {frame_q, {TLV_MGMT_ADDR, 1'b0}, 8'd4, 8'd5, SUBTYPE_IPV4, 8'hC0, 8'hA8};
        frame_q = {frame_q, {TLV_ORG_SPECIFIC, 1'b0}, 8'd6, 8'h00, 8'h12, 8'h0F,
                   SUBTYPE_PORT_VLAN, 8'h00, 8'h00};
        send_frame();

        // A name TLV of the largest length cut short by the end of the frame.
        push_header(1'b1);
        frame_q = {frame_q, {TLV_SYSTEM_NAME, 1'b1}, 8'hFF, 8'h00, 8'h7F, 8'h80};
        send_frame();

        tx_idle = 1'b1;
        rx_mode = RX_RANDOM;
        random_until(60);
        drain_pause();

        write_ethertype(16'h0000);
        tx_idle = 1'b0;
        hold_req = 1'b1;
        random_until(60);
        drain_pause();

        write_ethertype(16'hFFFF);
        tx_idle = 1'b1;
        rx_mode = RX_PATTERN;
        random_until(30);
        drain_pause();
        random_until(30);
        drain_pause();

        write_ethertype(16'($urandom_range(0, 65535)));
        tx_idle = 1'b0;
        rx_mode = RX_ALWAYS;
        random_until(60);
        drain_pause();

        write_ethertype(lte_pkg::ETHERTYPE_RESET);
        tx_idle = 1'b1;
        rx_mode = RX_RANDOM;
        random_until(60);
        drain_pause();

        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
